@@ rtl/core/socks5hs_pkg.sv @@
// Package with the shared types and protocol constants of the SOCKS5 handshake parser.
package socks5hs_pkg;

    localparam int REPLY_BEATS = 10;
    localparam int GREET_BEATS = 2;
    localparam int BEAT_W      = $clog2(REPLY_BEATS);

    localparam logic       OP_BYTE  = 1'b0;
    localparam logic       OP_EVENT = 1'b1;

    localparam logic [7:0] SOCKS_VER     = 8'h05;
    localparam logic [7:0] METHOD_NOAUTH = 8'h00;
    localparam logic [7:0] METHOD_NONE   = 8'hFF;
    localparam logic [7:0] CMD_CONNECT   = 8'h01;
    localparam logic [7:0] ATYP_IPV4     = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
    localparam logic [7:0] ATYP_IPV6     = 8'h04;
    localparam logic [7:0] REP_OK        = 8'h00;
    localparam logic [7:0] REP_GENERAL   = 8'h01;
    localparam logic [7:0] REP_REFUSED   = 8'h05;
    localparam logic [7:0] REP_BAD_CMD   = 8'h07;
    localparam logic [7:0] REP_BAD_ATYP  = 8'h08;
    localparam logic [7:0] REPLY_ATYP    = 8'h01;
    localparam logic [7:0] LEN_IPV4      = 8'd4;
    localparam logic [7:0] LEN_IPV6      = 8'd16;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_REPLY  = 2'd1;
    localparam logic [1:0] KIND_ADDR   = 2'd2;

    localparam logic [1:0] TK_IPV4   = 2'd0;
    localparam logic [1:0] TK_DOMAIN = 2'd1;
    localparam logic [1:0] TK_IPV6   = 2'd2;

    typedef enum logic [2:0] {
        PH_GREETING = 3'd0,
        PH_REQUEST  = 3'd1,
        PH_READY    = 3'd2,
        PH_DONE     = 3'd3,
        PH_FAILED   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        BU_STATUS = 2'd0,
        BU_ADDR   = 2'd1,
        BU_GREET  = 2'd2,
        BU_REPLY  = 2'd3
    } t_burst;

    typedef struct packed {
        t_burst      burst;
        logic [7:0]  data;
        logic [7:0]  idx;
        t_phase      phase;
        logic [1:0]  tkind;
        logic [15:0] port;
    } t_desc;

endpackage

@@ rtl/core/socks5hs_if.sv @@
// Valid/ready channel interfaces for the input items and the result items.
interface socks5hs_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;
    logic       connect_ok;

    modport source (output valid, output op, output data_byte, output connect_ok, input ready);
    modport sink   (input valid, input op, input data_byte, input connect_ok, output ready);
endinterface

interface socks5hs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [7:0]  addr_index;
    logic        last;
    logic [2:0]  phase_now;
    logic [1:0]  target_kind;
    logic [15:0] dest_port;

    modport source (output valid, output kind, output out_byte, output addr_index,
                    output last, output phase_now, output target_kind, output dest_port,
                    input ready);
    modport sink   (input valid, input kind, input out_byte, input addr_index,
                    input last, input phase_now, input target_kind, input dest_port,
                    output ready);
endinterface

@@ rtl/core/socks5_connect_handshake_parser.sv @@
// SOCKS5 server handshake parser: top level joining the parse stage and the result stage.
//
// Input channel i_req carries items: each is a client stream byte
// (op 0) or a connect outcome event (op 1). Output channel o_res carries the
// result items: status, reply bytes to the client and destination address bytes.
// Every item causes one result, two for the greeting answer, or ten for a full
// reply; the last one is flagged.
// An item accepted at one clock edge shows its first result after that edge.
// The parse state is updated at acceptance and the results wait in a single
// result register with a beat counter.
// Items that cause one result are taken one per cycle while the receiver is ready.
// An item that causes a burst holds the result register until the final result
// of the burst leaves, and the next item is taken in the cycle in which it leaves.
// When the receiver stalls, the result register holds its item and the input
// channel drops ready once the register cannot be freed in that cycle.
// Reset returns the parser to the greeting phase with all counters cleared and
// empties the result register.
module socks5_connect_handshake_parser
    import socks5hs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    socks5hs_in_if.sink    i_req,
    socks5hs_out_if.source o_res
);

    t_desc w_desc;
    logic  w_ready;
    logic  w_accept;

    assign i_req.ready = w_ready;
    assign w_accept    = i_req.valid && w_ready;

    socks5hs_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_op         (i_req.op),
        .i_data_byte  (i_req.data_byte),
        .i_connect_ok (i_req.connect_ok),
        .o_desc       (w_desc)
    );

    socks5hs_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_desc  (w_desc),
        .o_ready (w_ready),
        .o_res   (o_res)
    );

endmodule

@@ rtl/core/socks5hs_parse.sv @@
// Handshake state registers and the per-item parse logic that builds a result descriptor.
module socks5hs_parse
    import socks5hs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  logic  i_op,
    input  logic  [7:0] i_data_byte,
    input  logic  i_connect_ok,
    output t_desc o_desc
);

    t_phase      r_phase,  n_phase;
    logic [8:0]  r_count,  n_count;
    logic [7:0]  r_first,  n_first;
    logic [7:0]  r_mtotal, n_mtotal;
    logic        r_noauth, n_noauth;
    logic [1:0]  r_akind,  n_akind;
    logic [7:0]  r_alen,   n_alen;
    logic [15:0] r_port,   n_port;

    logic [8:0]  w_next;
    logic [8:0]  w_mend;
    logic [8:0]  w_start;
    logic [8:0]  w_end;
    logic [8:0]  w_off;

    assign w_next  = r_count + 9'd1;
    assign w_mend  = {1'b0, r_mtotal} + 9'd1;
    assign w_start = (r_akind == TK_DOMAIN) ? 9'd5 : 9'd4;
    assign w_end   = w_start + {1'b0, r_alen};
    assign w_off   = r_count - w_start;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_first  = r_first;
        n_mtotal = r_mtotal;
        n_noauth = r_noauth;
        n_akind  = r_akind;
        n_alen   = r_alen;
        n_port   = r_port;
        o_desc.burst = BU_STATUS;
        o_desc.data  = 8'd0;
        o_desc.idx   = 8'd0;
        if (i_op == OP_BYTE) begin
            case (r_phase)
                PH_GREETING: begin
                    n_count = w_next;
                    if (r_count == 9'd0) begin
                        n_first = i_data_byte;
                    end else if (r_count == 9'd1) begin
                        if (r_first != SOCKS_VER) begin
                            n_phase = PH_FAILED;
                        end else begin
                            n_mtotal = i_data_byte;
                            n_noauth = 1'b0;
                            if (i_data_byte == 8'd0) begin
                                o_desc.burst = BU_GREET;
                                o_desc.data  = METHOD_NONE;
                                n_phase      = PH_FAILED;
                                n_count      = 9'd0;
                            end
                        end
                    end else begin
                        if (i_data_byte == METHOD_NOAUTH) begin
                            n_noauth = 1'b1;
                        end
                        if (r_count >= w_mend) begin
                            o_desc.burst = BU_GREET;
                            o_desc.data  = n_noauth ? METHOD_NOAUTH : METHOD_NONE;
                            n_phase      = n_noauth ? PH_REQUEST : PH_FAILED;
                            n_count      = 9'd0;
                        end
                    end
                end
                PH_REQUEST: begin
                    n_count = w_next;
                    if (r_count == 9'd0) begin
                        n_first = i_data_byte;
                    end else if (r_count == 9'd1) begin
                        n_mtotal = i_data_byte;
                    end else if (r_count == 9'd2) begin
                        n_mtotal = r_mtotal;
                    end else if (r_count == 9'd3) begin
                        if (r_first != SOCKS_VER) begin
                            o_desc.burst = BU_REPLY;
                            o_desc.data  = REP_GENERAL;
                            n_phase      = PH_FAILED;
                        end else if (r_mtotal != CMD_CONNECT) begin
                            o_desc.burst = BU_REPLY;
                            o_desc.data  = REP_BAD_CMD;
                            n_phase      = PH_FAILED;
                        end else if (i_data_byte == ATYP_IPV4) begin
                            n_akind = TK_IPV4;
                            n_alen  = LEN_IPV4;
                        end else if (i_data_byte == ATYP_IPV6) begin
                            n_akind = TK_IPV6;
                            n_alen  = LEN_IPV6;
                        end else if (i_data_byte == ATYP_DOMAIN) begin
                            n_akind = TK_DOMAIN;
                            n_alen  = 8'd0;
                        end else begin
                            o_desc.burst = BU_REPLY;
                            o_desc.data  = REP_BAD_ATYP;
                            n_phase      = PH_FAILED;
                        end
                    end else if (r_akind == TK_DOMAIN && r_count == 9'd4) begin
                        if (i_data_byte == 8'd0) begin
                            o_desc.burst = BU_REPLY;
                            o_desc.data  = REP_BAD_ATYP;
                            n_phase      = PH_FAILED;
                        end else begin
                            n_alen = i_data_byte;
                        end
                    end else if (r_count < w_end) begin
                        o_desc.burst = BU_ADDR;
                        o_desc.data  = i_data_byte;
                        o_desc.idx   = w_off[7:0];
                    end else begin
                        n_port = {r_port[7:0], i_data_byte};
                        if (r_count == w_end + 9'd1) begin
                            n_phase = PH_READY;
                            n_count = 9'd0;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end else if (r_phase == PH_READY) begin
            o_desc.burst = BU_REPLY;
            o_desc.data  = i_connect_ok ? REP_OK : REP_REFUSED;
            n_phase      = i_connect_ok ? PH_DONE : PH_FAILED;
        end
        o_desc.phase = n_phase;
        o_desc.tkind = n_akind;
        o_desc.port  = (n_phase == PH_READY || n_phase == PH_DONE) ? n_port : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_GREETING;
            r_count  <= 9'd0;
            r_first  <= 8'd0;
            r_mtotal <= 8'd0;
            r_noauth <= 1'b0;
            r_akind  <= TK_IPV4;
            r_alen   <= 8'd0;
            r_port   <= 16'd0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_first  <= n_first;
            r_mtotal <= n_mtotal;
            r_noauth <= n_noauth;
            r_akind  <= n_akind;
            r_alen   <= n_alen;
            r_port   <= n_port;
        end
    end

endmodule

@@ rtl/core/socks5hs_emit.sv @@
// Result register that plays out one descriptor as one, two or ten result items.
module socks5hs_emit
    import socks5hs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_desc i_desc,
    output logic  o_ready,
    socks5hs_out_if.source o_res
);

    logic              r_valid;
    t_desc             r_desc;
    logic [BEAT_W-1:0] r_beat;
    logic              w_last;
    logic              w_take;
    logic [7:0]        w_reply;

    always_comb begin
        case (r_desc.burst)
            BU_GREET: w_last = (r_beat == BEAT_W'(GREET_BEATS - 1));
            BU_REPLY: w_last = (r_beat == BEAT_W'(REPLY_BEATS - 1));
            default:  w_last = 1'b1;
        endcase
        case (r_beat)
            BEAT_W'(0): w_reply = SOCKS_VER;
            BEAT_W'(1): w_reply = r_desc.data;
            BEAT_W'(3): w_reply = REPLY_ATYP;
            default:    w_reply = 8'h00;
        endcase
    end

    assign w_take  = r_valid && o_res.ready;
    assign o_ready = !r_valid || (w_take && w_last);

    assign o_res.valid       = r_valid;
    assign o_res.last        = w_last;
    assign o_res.phase_now   = r_desc.phase;
    assign o_res.target_kind = r_desc.tkind;
    assign o_res.dest_port   = r_desc.port;
    assign o_res.kind        = (r_desc.burst == BU_STATUS) ? KIND_STATUS :
                               (r_desc.burst == BU_ADDR)   ? KIND_ADDR : KIND_REPLY;
    assign o_res.out_byte    = (r_desc.burst == BU_STATUS) ? 8'h00 :
                               (r_desc.burst == BU_ADDR)   ? r_desc.data : w_reply;
    assign o_res.addr_index  = (r_desc.burst == BU_ADDR) ? r_desc.idx : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_beat  <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_beat <= r_beat + BEAT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_desc <= i_desc;
        end
    end

endmodule

@@ rtl/core/socks5hs_check.sv @@
// Port-level assertions for the SOCKS5 handshake parser and their bind to the top level.
module socks5hs_check
    import socks5hs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_kind,
    input logic [7:0]  i_out_byte,
    input logic        i_last,
    input logic [2:0]  i_phase_now,
    input logic [15:0] i_dest_port
);

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == KIND_STATUS |-> i_last)
        else $error("A status result is not the last result of its item.");

    a_addr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == KIND_ADDR |-> i_phase_now == PH_REQUEST)
        else $error("An address byte appears outside the request phase.");

    a_port_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_phase_now != PH_READY && i_phase_now != PH_DONE |-> i_dest_port == 16'd0)
        else $error("A port is reported before the ready phase.");

    a_reply_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && i_kind != KIND_REPLY |=> !i_valid || i_kind != KIND_REPLY ||
        i_out_byte == SOCKS_VER)
        else $error("A reply burst does not start with the version byte.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_out_byte) &&
        $stable(i_last))
        else $error("A stalled result item changed.");

endmodule

bind socks5_connect_handshake_parser socks5hs_check u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_res.valid),
    .i_ready     (o_res.ready),
    .i_kind      (o_res.kind),
    .i_out_byte  (o_res.out_byte),
    .i_last      (o_res.last),
    .i_phase_now (o_res.phase_now),
    .i_dest_port (o_res.dest_port)
);

@@ tb/socks5hs_result_checker.sv @@
// Checker that predicts the handshake parser's result items from accepted input items and compares them.
module socks5hs_result_checker
    import socks5hs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    socks5hs_in_if  i_req,
    socks5hs_out_if i_res,
    output int      o_error_count,
    output int      o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] RSV_BYTE  = 8'h00;
    localparam int         PRINT_CAP = 40;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [7:0]  addr_index;
        logic        last;
        t_phase      phase_now;
        logic [1:0]  target_kind;
        logic [15:0] dest_port;
    } t_result;

    t_phase      phase_q;
    logic [8:0]  pos_q;
    logic [7:0]  ver_q;
    logic [7:0]  count_q;
    logic        noauth_q;
    logic [1:0]  tk_q;
    logic [7:0]  len_q;
    logic [15:0] port_q;

    t_result beat_buf[$];
    t_result predicted_results[$];
    int      errors  = 0;
    int      checked = 0;

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_CAP) begin
            $display("ERROR at result %0d: %s", checked, msg);
        end
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    function automatic void add_beat(input logic [1:0] kind, input logic [7:0] b,
                                     input logic [7:0] idx);
        t_result r;
        r            = '0;
        r.kind       = kind;
        r.out_byte   = b;
        r.addr_index = idx;
        beat_buf     = {beat_buf, r};
    endfunction

    function automatic void add_reply(input logic [7:0] code);
        add_beat(KIND_REPLY, SOCKS_VER, 8'd0);
        add_beat(KIND_REPLY, code, 8'd0);
        add_beat(KIND_REPLY, RSV_BYTE, 8'd0);
        add_beat(KIND_REPLY, REPLY_ATYP, 8'd0);
        repeat (6) add_beat(KIND_REPLY, 8'h00, 8'd0);
    endfunction

    function automatic void reject(input logic [7:0] code);
        add_reply(code);
        phase_q = PH_FAILED;
    endfunction

    function automatic void answer_greeting();
        add_beat(KIND_REPLY, SOCKS_VER, 8'd0);
        add_beat(KIND_REPLY, noauth_q ? METHOD_NOAUTH : METHOD_NONE, 8'd0);
        phase_q = noauth_q ? PH_REQUEST : PH_FAILED;
        pos_q   = '0;
    endfunction

    function automatic void take_greeting_byte(input logic [7:0] b);
        logic [8:0] c;
        c     = pos_q;
        pos_q = pos_q + 9'd1;
        if (c == 9'd0) begin
            ver_q = b;
        end else if (c == 9'd1) begin
            if (ver_q != SOCKS_VER) begin
                phase_q = PH_FAILED;
            end else begin
                count_q  = b;
                noauth_q = 1'b0;
                if (b == 8'd0) answer_greeting();
            end
        end else begin
            if (b == METHOD_NOAUTH) noauth_q = 1'b1;
            if (int'(c) >= 1 + int'(count_q)) answer_greeting();
        end
    endfunction

    function automatic void take_request_byte(input logic [7:0] b);
        logic [8:0] c;
        int         start;
        c     = pos_q;
        pos_q = pos_q + 9'd1;
        if (c == 9'd0) begin
            ver_q = b;
        end else if (c == 9'd1) begin
            count_q = b;
        end else if (c == 9'd3) begin
            if (ver_q != SOCKS_VER) begin
                reject(REP_GENERAL);
            end else if (count_q != CMD_CONNECT) begin
                reject(REP_BAD_CMD);
            end else if (b == ATYP_IPV4) begin
                tk_q  = TK_IPV4;
                len_q = LEN_IPV4;
            end else if (b == ATYP_IPV6) begin
                tk_q  = TK_IPV6;
                len_q = LEN_IPV6;
            end else if (b == ATYP_DOMAIN) begin
                tk_q  = TK_DOMAIN;
                len_q = 8'd0;
            end else begin
                reject(REP_BAD_ATYP);
            end
        end else if (c > 9'd3) begin
            start = 4;
            if (tk_q == TK_DOMAIN) begin
                start = 5;
                if (c == 9'd4) begin
                    if (b == 8'd0) begin
                        reject(REP_BAD_ATYP);
                    end else begin
                        len_q = b;
                    end
                    return;
                end
            end
            if (int'(c) < start + int'(len_q)) begin
                add_beat(KIND_ADDR, b, 8'(int'(c) - start));
            end else begin
                port_q = {port_q[7:0], b};
                if (int'(c) == start + int'(len_q) + 1) begin
                    phase_q = PH_READY;
                    pos_q   = '0;
                end
            end
        end
    endfunction

    function automatic void predict_handshake(input logic op, input logic [7:0] b,
                                              input logic ok);
        logic [15:0] port;
        t_result     r;
        beat_buf.delete();
        if (op == OP_BYTE) begin
            if (phase_q == PH_GREETING) begin
                take_greeting_byte(b);
            end else if (phase_q == PH_REQUEST) begin
                take_request_byte(b);
            end
        end else if (phase_q == PH_READY) begin
            add_reply(ok ? REP_OK : REP_REFUSED);
            phase_q = ok ? PH_DONE : PH_FAILED;
        end
        if (beat_buf.size() == 0) add_beat(KIND_STATUS, 8'd0, 8'd0);
        port = (phase_q == PH_READY || phase_q == PH_DONE) ? port_q : 16'd0;
        foreach (beat_buf[k]) begin
            r                 = beat_buf[k];
            r.last            = (k == beat_buf.size() - 1);
            r.phase_now       = phase_q;
            r.target_kind     = tk_q;
            r.dest_port       = port;
            predicted_results = {predicted_results, r};
        end
    endfunction

    task automatic check_result();
        t_result want;
        if (predicted_results.size() == 0) begin
            report_mismatch("result item arrived with nothing expected");
        end else begin
            want = predicted_results.pop_front();
            compare_field("kind", 16'(i_res.kind), 16'(want.kind));
            compare_field("out_byte", 16'(i_res.out_byte), 16'(want.out_byte));
            compare_field("addr_index", 16'(i_res.addr_index), 16'(want.addr_index));
            compare_field("last", 16'(i_res.last), 16'(want.last));
            compare_field("phase_now", 16'(i_res.phase_now), 16'(want.phase_now));
            compare_field("target_kind", 16'(i_res.target_kind), 16'(want.target_kind));
            compare_field("dest_port", i_res.dest_port, want.dest_port);
        end
        checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase_q  = PH_GREETING;
            pos_q    = '0;
            ver_q    = '0;
            count_q  = '0;
            noauth_q = 1'b0;
            tk_q     = '0;
            len_q    = '0;
            port_q   = '0;
            predicted_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) check_result();
            if (i_req.valid && i_req.ready) begin
                predict_handshake(i_req.op, i_req.data_byte, i_req.connect_ok);
            end
        end
        o_error_count <= errors;
        o_outstanding <= predicted_results.size();
    end

endmodule

@@ tb/tb.sv @@
// Testbench top that drives one randomized SOCKS5 handshake through the parser and gives the verdict.
module tb;
    import socks5hs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 230;
    localparam int DRAIN_CYCLES = 4;

    typedef enum int {
        PATH_BAD_GREET_VER = 0,
        PATH_NO_NOAUTH     = 1,
        PATH_EMPTY_LIST    = 2,
        PATH_BAD_REQ_VER   = 3,
        PATH_BAD_CMD       = 4,
        PATH_BAD_ATYP      = 5,
        PATH_EMPTY_DOMAIN  = 6,
        PATH_GOOD          = 7
    } t_path;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   error_count;
    int   outstanding;
    int   cycle_count = 0;
    int   items_sent  = 0;
    bit   no_idle     = 1'b0;

    socks5hs_in_if  req_ch();
    socks5hs_out_if res_ch();

    socks5_connect_handshake_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    socks5hs_result_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_res         (res_ch),
        .o_error_count (error_count),
        .o_outstanding (outstanding)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    task automatic send_item(input logic op, input logic [7:0] b, input logic ok);
        int gap;
        if (items_sent % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.data_byte  <= b;
        req_ch.connect_ok <= ok;
        do @(posedge i_clk); while (!req_ch.ready);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 15) == 0) begin
            send_item(OP_EVENT, 8'($urandom), 1'($urandom_range(0, 1)));
        end
        send_item(OP_BYTE, b, 1'b0);
    endtask

    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic run_handshake();
        t_path      path;
        int         pick;
        int         n_methods;
        int         addr_len;
        int         noauth_pos;
        int         drops;
        logic [1:0] tk;
        logic [7:0] b;
        pick  = $urandom_range(0, 15);
        path  = (pick < 7) ? t_path'(pick) : PATH_GOOD;
        tk    = 2'($urandom_range(0, 2));
        drops = $urandom_range(0, 3);
        if (tk == TK_IPV4) begin
            addr_len = int'(LEN_IPV4);
        end else if (tk == TK_IPV6) begin
            addr_len = int'(LEN_IPV6);
        end else begin
            addr_len = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 24);
        end
        if (path == PATH_GOOD) begin
            n_methods = RANDOM_ITEMS - 2 - (7 + addr_len + drops + ((tk == TK_DOMAIN) ? 1 : 0));
            if (n_methods < 1) n_methods = 1;
            if (n_methods > 255) n_methods = 255;
        end else begin
            n_methods = $urandom_range(1, 40);
        end

        if (path == PATH_BAD_GREET_VER) begin
            do b = 8'($urandom); while (b == SOCKS_VER);
            send_byte(b);
            send_byte(8'($urandom));
            return;
        end
        send_byte(SOCKS_VER);
        if (path == PATH_EMPTY_LIST) begin
            send_byte(8'd0);
            return;
        end
        send_byte(8'(n_methods));
        noauth_pos = $urandom_range(0, n_methods - 1);
        for (int i = 0; i < n_methods; i++) begin
            if (path == PATH_NO_NOAUTH) begin
                b = 8'($urandom_range(1, 255));
            end else if (i == noauth_pos) begin
                b = METHOD_NOAUTH;
            end else begin
                b = 8'($urandom);
            end
            send_byte(b);
        end
        if (path == PATH_NO_NOAUTH) return;
        hold_until_drained();

        b = SOCKS_VER;
        if (path == PATH_BAD_REQ_VER) begin
            do b = 8'($urandom); while (b == SOCKS_VER);
        end
        send_byte(b);
        b = CMD_CONNECT;
        if (path == PATH_BAD_CMD) begin
            do b = 8'($urandom); while (b == CMD_CONNECT);
        end else if (path == PATH_BAD_REQ_VER && $urandom_range(0, 1) == 1) begin
            b = 8'($urandom);
        end
        send_byte(b);
        send_byte(8'($urandom));
        if (path == PATH_BAD_ATYP) begin
            do b = 8'($urandom);
            while (b == ATYP_IPV4 || b == ATYP_DOMAIN || b == ATYP_IPV6);
        end else if (path == PATH_EMPTY_DOMAIN || tk == TK_DOMAIN) begin
            b = ATYP_DOMAIN;
        end else if (tk == TK_IPV6) begin
            b = ATYP_IPV6;
        end else begin
            b = ATYP_IPV4;
        end
        send_byte(b);
        if (path == PATH_BAD_REQ_VER || path == PATH_BAD_CMD || path == PATH_BAD_ATYP) return;
        if (path == PATH_EMPTY_DOMAIN) begin
            send_byte(8'd0);
            return;
        end
        if (tk == TK_DOMAIN) send_byte(8'(addr_len));
        repeat (addr_len) send_byte(8'($urandom));
        repeat (2) begin
            pick = $urandom_range(0, 3);
            send_byte((pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom));
        end
        repeat (drops) send_item(OP_BYTE, 8'($urandom), 1'($urandom_range(0, 1)));
        send_item(OP_EVENT, 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        req_ch.valid      <= 1'b0;
        req_ch.op         <= OP_BYTE;
        req_ch.data_byte  <= 8'h00;
        req_ch.connect_ok <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Outcome events that arrive before the greeting must be ignored.
        send_item(OP_EVENT, 8'h00, 1'b0);
        send_item(OP_EVENT, 8'hFF, 1'b1);

        run_handshake();
        hold_until_drained();

        // Once the handshake has ended, every further item is dropped.
        send_item(OP_BYTE, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'hFF, 1'b1);
        send_item(OP_EVENT, 8'h5A, 1'b1);
        send_item(OP_EVENT, 8'hA5, 1'b0);
        repeat (12) send_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
        while (items_sent < RANDOM_ITEMS) begin
            send_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
        end

        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && outstanding == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
